// File: src/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg: shared types for the source tokenizer
// Token kinds, the token record and the queue entry that carries the one or
// two tokens that one source byte produces from the front end to the back end.
// ----------------------------------------------------------------------------
package stl_pkg;

  // Token kind codes as they appear on the result port
  typedef enum logic [4:0] {
    KIND_INT    = 5'd0,
    KIND_IDENT  = 5'd1,
    KIND_PLUS   = 5'd2,
    KIND_MINUS  = 5'd3,
    KIND_STAR   = 5'd4,
    KIND_LPAREN = 5'd5,
    KIND_RPAREN = 5'd6,
    KIND_LBRACE = 5'd7,
    KIND_RBRACE = 5'd8,
    KIND_ASSIGN = 5'd9,
    KIND_SLASH  = 5'd10,
    KIND_SEMI   = 5'd11,
    KIND_EOF    = 5'd12,
    KIND_IF     = 5'd13,
    KIND_ELSE   = 5'd14,
    KIND_AND    = 5'd15,
    KIND_OR     = 5'd16,
    KIND_EQ     = 5'd17,
    KIND_GT     = 5'd18,
    KIND_GE     = 5'd19,
    KIND_LT     = 5'd20,
    KIND_LE     = 5'd21,
    KIND_NE     = 5'd22,
    KIND_ERROR  = 5'd23
  } kind_e;

  // Fixed widths of the result fields
  localparam int unsigned StartBits = 32;
  localparam int unsigned LenBits   = 16;

  // Queue between front and back end
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);

  // One finished token, start and length already saturated
  typedef struct packed {
    kind_e                kind;
    logic [StartBits-1:0] start;
    logic [LenBits-1:0]   length;
  } token_t;

  // Tokens caused by one source byte; tok1 is used only when two is set
  typedef struct packed {
    token_t tok0;
    token_t tok1;
    logic   two;
  } entry_t;

endpackage

// File: src/source_tokenizer_top.sv
// A byte's first token shows after a queue slot and the back-end entry
// register; its second token shows once the first is popped. Throughput:
// one byte per cycle in unless full, one token per cycle out unless empty
// or not popped; a four-entry queue absorbs bytes that complete two tokens.
// Reset: rst_ni clears lexer state, offsets and queue; no clearing pass.
// ----------------------------------------------------------------------------
// source_tokenizer_top: streaming source lexer
// Takes one source byte or end-of-input mark per transaction and returns
// tokens as kind, start offset and length.
// ----------------------------------------------------------------------------
module source_tokenizer_top #(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned LENGTH_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  source_byte_i,
  input  logic        end_of_input_i,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  token_kind_o,
  output logic [31:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);

  logic            accept;
  logic            wr_valid, rd_valid, rd_pop;
  stl_pkg::entry_t wr_entry, rd_entry;

  assign accept = push && !full;

  // Front end: lexer state and classification
  stl_front #(
    .POSITION_BITS(POSITION_BITS),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .source_byte_i (source_byte_i),
    .end_of_input_i(end_of_input_i),
    .entry_valid_o (wr_valid),
    .entry_o       (wr_entry)
  );

  // Decoupling queue
  stl_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(wr_valid),
    .wr_entry_i(wr_entry),
    .full_o    (full),
    .rd_valid_o(rd_valid),
    .rd_entry_o(rd_entry),
    .rd_pop_i  (rd_pop)
  );

  // Back end: token output
  stl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_valid_i    (rd_valid),
    .rd_entry_i    (rd_entry),
    .rd_pop_o      (rd_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .token_kind_o  (token_kind_o),
    .token_start_o (token_start_o),
    .token_length_o(token_length_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// File: src/stl_front.sv
// ----------------------------------------------------------------------------
// stl_front: lexer front end
// Classifies one byte per cycle while accept_i is high, checking it against
// the lexer state, and builds the queue entry of the tokens it completes.
// ----------------------------------------------------------------------------
module stl_front #(
  parameter int unsigned POSITION_BITS = 32,
  parameter int unsigned LENGTH_BITS   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       source_byte_i,
  input  logic             end_of_input_i,
  output logic             entry_valid_o,
  output stl_pkg::entry_t  entry_o
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_INT,
    MODE_OPER
  } mode_e;

  typedef enum logic [1:0] {
    OP_EQ,
    OP_GT,
    OP_LT,
    OP_BANG
  } oper_e;

  // Character codes
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDel    = 8'h7F;

  // Keyword patterns, first byte lowest
  localparam logic [31:0] KwIf   = 32'h0000_6669;
  localparam logic [31:0] KwElse = 32'h6573_6C65;
  localparam logic [31:0] KwAnd  = 32'h0064_6E61;
  localparam logic [31:0] KwOr   = 32'h0000_726F;

  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam logic [LENGTH_BITS-1:0]   LenMax = '1;

  mode_e                     mode_q, mode_d;
  oper_e                     oper_q, oper_d;
  logic [POSITION_BITS-1:0]  start_q, start_d;
  logic [LENGTH_BITS-1:0]    len_q, len_d;
  logic [31:0]               prefix_q, prefix_d;
  logic [POSITION_BITS-1:0]  pos_q, pos_d;

  logic                      is_letter, is_digit, is_skip;
  logic [63:0]               start_ext, pos_ext;
  logic [31:0]               len_ext;
  logic [stl_pkg::StartBits-1:0] start_sat, pos_sat;
  logic [stl_pkg::LenBits-1:0]   len_sat;
  stl_pkg::kind_e            ident_kind, single_kind, pair_kind;
  logic                      flush_v, sec_v;
  stl_pkg::token_t           flush_tok, sec_tok;

  // Byte classes
  assign is_letter = (source_byte_i >= 8'h61 && source_byte_i <= 8'h7A) ||
                     (source_byte_i >= 8'h41 && source_byte_i <= 8'h5A) ||
                     (source_byte_i == ChUnder);
  assign is_digit  = (source_byte_i >= 8'h30 && source_byte_i <= 8'h39);
  assign is_skip   = (source_byte_i <= ChSpace) || (source_byte_i >= ChDel);

  // Saturate offsets and length to the result field widths
  assign start_ext = 64'(start_q);
  assign pos_ext   = 64'(pos_q);
  assign len_ext   = 32'(len_q);
  assign start_sat = (|start_ext[63:32]) ? '1 : start_ext[31:0];
  assign pos_sat   = (|pos_ext[63:32])   ? '1 : pos_ext[31:0];
  assign len_sat   = (|len_ext[31:16])   ? '1 : len_ext[15:0];

  // Identifier kind, keywords only at lengths 2 to 4
  always_comb begin
    ident_kind = stl_pkg::KIND_IDENT;
    if (len_ext == 32'd2 && prefix_q == KwIf) begin
      ident_kind = stl_pkg::KIND_IF;
    end else if (len_ext == 32'd4 && prefix_q == KwElse) begin
      ident_kind = stl_pkg::KIND_ELSE;
    end else if (len_ext == 32'd3 && prefix_q == KwAnd) begin
      ident_kind = stl_pkg::KIND_AND;
    end else if (len_ext == 32'd2 && prefix_q == KwOr) begin
      ident_kind = stl_pkg::KIND_OR;
    end
  end

  // Kinds for a pending operator, alone or joined with '='
  always_comb begin
    case (oper_q)
      OP_EQ: begin
        single_kind = stl_pkg::KIND_ASSIGN;
        pair_kind   = stl_pkg::KIND_EQ;
      end
      OP_GT: begin
        single_kind = stl_pkg::KIND_GT;
        pair_kind   = stl_pkg::KIND_GE;
      end
      OP_LT: begin
        single_kind = stl_pkg::KIND_LT;
        pair_kind   = stl_pkg::KIND_LE;
      end
      default: begin
        single_kind = stl_pkg::KIND_ERROR;
        pair_kind   = stl_pkg::KIND_NE;
      end
    endcase
  end

  // Token that a flush of the pending state produces
  always_comb begin
    flush_tok.start = start_sat;
    case (mode_q)
      MODE_IDENT: begin
        flush_tok.kind   = ident_kind;
        flush_tok.length = len_sat;
      end
      MODE_INT: begin
        flush_tok.kind   = stl_pkg::KIND_INT;
        flush_tok.length = len_sat;
      end
      default: begin
        flush_tok.kind   = single_kind;
        flush_tok.length = stl_pkg::LenBits'(1);
      end
    endcase
  end

  // Lexer step for one accepted transaction
  always_comb begin
    mode_d   = mode_q;
    oper_d   = oper_q;
    start_d  = start_q;
    len_d    = len_q;
    prefix_d = prefix_q;
    pos_d    = pos_q;
    flush_v  = 1'b0;
    sec_v    = 1'b0;
    sec_tok.kind   = stl_pkg::KIND_ERROR;
    sec_tok.start  = pos_sat;
    sec_tok.length = stl_pkg::LenBits'(1);

    if (accept_i) begin
      if (end_of_input_i) begin
        flush_v        = (mode_q != MODE_IDLE);
        mode_d         = MODE_IDLE;
        sec_v          = 1'b1;
        sec_tok.kind   = stl_pkg::KIND_EOF;
        sec_tok.length = '0;
      end else begin
        if (pos_q != PosMax) begin
          pos_d = pos_q + 1'b1;
        end
        if (mode_q == MODE_IDENT && (is_letter || is_digit)) begin
          // extend identifier, first four bytes kept for keyword match
          if (len_ext < 32'd4) begin
            case (len_q[1:0])
              2'd1:    prefix_d[15:8]  = source_byte_i;
              2'd2:    prefix_d[23:16] = source_byte_i;
              2'd3:    prefix_d[31:24] = source_byte_i;
              default: prefix_d[7:0]   = source_byte_i;
            endcase
          end
          if (len_q != LenMax) begin
            len_d = len_q + 1'b1;
          end
        end else if (mode_q == MODE_INT && is_digit) begin
          if (len_q != LenMax) begin
            len_d = len_q + 1'b1;
          end
        end else if (mode_q == MODE_OPER && source_byte_i == ChEq) begin
          // two-byte operator
          sec_v          = 1'b1;
          sec_tok.kind   = pair_kind;
          sec_tok.start  = start_sat;
          sec_tok.length = stl_pkg::LenBits'(2);
          mode_d         = MODE_IDLE;
        end else begin
          flush_v = (mode_q != MODE_IDLE);
          mode_d  = MODE_IDLE;
          // lex the byte afresh
          if (is_letter || is_digit) begin
            mode_d   = is_letter ? MODE_IDENT : MODE_INT;
            start_d  = pos_q;
            len_d    = LENGTH_BITS'(1);
            prefix_d = 32'(source_byte_i);
          end else if (!is_skip) begin
            case (source_byte_i)
              ChEq, ChGt, ChLt, ChBang: begin
                mode_d   = MODE_OPER;
                start_d  = pos_q;
                len_d    = LENGTH_BITS'(1);
                prefix_d = 32'(source_byte_i);
                if (source_byte_i == ChEq) begin
                  oper_d = OP_EQ;
                end else if (source_byte_i == ChGt) begin
                  oper_d = OP_GT;
                end else if (source_byte_i == ChLt) begin
                  oper_d = OP_LT;
                end else begin
                  oper_d = OP_BANG;
                end
              end
              ChPlus: begin
                sec_v = 1'b1; sec_tok.kind = stl_pkg::KIND_PLUS;
              end
              ChMinus: begin
                sec_v = 1'b1; sec_tok.kind = stl_pkg::KIND_MINUS;
              end
              ChStar: begin
                sec_v = 1'b1; sec_tok.kind = stl_pkg::KIND_STAR;
              end
              ChLparen: begin
                sec_v = 1'b1; sec_tok.kind = stl_pkg::KIND_LPAREN;
              end
              ChRparen: begin
                sec_v = 1'b1; sec_tok.kind = stl_pkg::KIND_RPAREN;
              end
              ChLbrace: begin
                sec_v = 1'b1; sec_tok.kind = stl_pkg::KIND_LBRACE;
              end
              ChRbrace: begin
                sec_v = 1'b1; sec_tok.kind = stl_pkg::KIND_RBRACE;
              end
              ChSlash: begin
                sec_v = 1'b1; sec_tok.kind = stl_pkg::KIND_SLASH;
              end
              ChSemi: begin
                sec_v = 1'b1; sec_tok.kind = stl_pkg::KIND_SEMI;
              end
              default: begin
                sec_v = 1'b1; sec_tok.kind = stl_pkg::KIND_ERROR;
              end
            endcase
          end
        end
      end
    end
  end

  // Pack flushed token first, then the new one
  always_comb begin
    entry_valid_o = accept_i && (flush_v || sec_v);
    if (flush_v) begin
      entry_o.tok0 = flush_tok;
      entry_o.tok1 = sec_tok;
      entry_o.two  = sec_v;
    end else begin
      entry_o.tok0 = sec_tok;
      entry_o.tok1 = sec_tok;
      entry_o.two  = 1'b0;
    end
  end

  // Lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      oper_q   <= OP_EQ;
      start_q  <= '0;
      len_q    <= '0;
      prefix_q <= '0;
      pos_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      oper_q   <= oper_d;
      start_q  <= start_d;
      len_q    <= len_d;
      prefix_q <= prefix_d;
      pos_q    <= pos_d;
    end
  end

endmodule

// File: src/stl_queue.sv
// ----------------------------------------------------------------------------
// stl_queue: token entry queue
// Short first-in first-out queue that decouples the lexer front end from
// the result back end.
// ----------------------------------------------------------------------------
module stl_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  input  stl_pkg::entry_t wr_entry_i,
  output logic            full_o,
  output logic            rd_valid_o,
  output stl_pkg::entry_t rd_entry_o,
  input  logic            rd_pop_i
);

  localparam int unsigned CntBits = stl_pkg::QueuePtrBits + 1;

  stl_pkg::entry_t                   slots_q [stl_pkg::QueueDepth];
  logic [stl_pkg::QueuePtrBits-1:0]  wptr_q, rptr_q;
  logic [CntBits-1:0]                cnt_q;
  logic                              do_wr, do_rd;

  assign full_o     = (cnt_q == CntBits'(stl_pkg::QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_entry_o = slots_q[rptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wptr_q] <= wr_entry_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: src/stl_back.sv
// ----------------------------------------------------------------------------
// stl_back: result back end
// Holds one queue entry and hands out its tokens one transaction at a time,
// marking the last token caused by the source byte.
// ----------------------------------------------------------------------------
module stl_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_valid_i,
  input  stl_pkg::entry_t rd_entry_i,
  output logic            rd_pop_o,
  output logic            empty_o,
  input  logic            pop_i,
  output logic [4:0]      token_kind_o,
  output logic [31:0]     token_start_o,
  output logic [15:0]     token_length_o,
  output logic            last_of_run_o
);

  stl_pkg::entry_t cur_q;
  logic            cur_v_q;
  logic            sel_q;
  logic            is_last, taken;
  stl_pkg::token_t tok;

  assign tok       = sel_q ? cur_q.tok1 : cur_q.tok0;
  assign is_last   = sel_q || !cur_q.two;
  assign taken     = pop_i && cur_v_q;
  assign rd_pop_o  = rd_valid_i && (!cur_v_q || (taken && is_last));

  assign empty_o        = !cur_v_q;
  assign token_kind_o   = tok.kind;
  assign token_start_o  = tok.start;
  assign token_length_o = tok.length;
  assign last_of_run_o  = is_last;

  // Current entry payload
  always_ff @(posedge clk_i) begin
    if (rd_pop_o) begin
      cur_q <= rd_entry_i;
    end
  end

  // Valid flag and token select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      if (rd_pop_o) begin
        cur_v_q <= 1'b1;
        sel_q   <= 1'b0;
      end else if (taken) begin
        if (is_last) begin
          cur_v_q <= 1'b0;
          sel_q   <= 1'b0;
        end else begin
          sel_q <= 1'b1;
        end
      end
    end
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the source tokenizer
// Feeds source bytes and end-of-input marks through the push/full side while
// the pop/empty side is drained on a varying stall pattern. Every accepted
// byte runs through a lexer model held in a scoreboard class. Each token that
// is popped is compared, field by field, with the oldest predicted token.
// ----------------------------------------------------------------------------
package tb_lexer_pkg;

  // Lexer model plus the store of tokens still to arrive
  class token_scoreboard;
    typedef enum logic [1:0] {LX_IDLE, LX_IDENT, LX_INT, LX_OP} lex_state_e;
    typedef enum logic [1:0] {OP_ASSIGN, OP_GT, OP_LT, OP_BANG} held_op_e;
    typedef struct packed {
      stl_pkg::token_t tok;
      logic            last;
    } expected_token_t;

    lex_state_e        state;
    held_op_e          held_op;
    logic [31:0]       tok_start;
    logic [15:0]       tok_len;
    logic [31:0]       word_bytes;   // first four identifier bytes, first lowest
    logic [31:0]       next_offset;
    stl_pkg::token_t   step_tokens[$];
    expected_token_t   pending_tokens[$];
    int unsigned       n_errors;

    function new();
      state       = LX_IDLE;
      held_op     = OP_ASSIGN;
      tok_start   = '0;
      tok_len     = '0;
      word_bytes  = '0;
      next_offset = '0;
      n_errors    = 0;
    endfunction

    static function bit is_letter(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    static function bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function void add_token(stl_pkg::kind_e k, logic [31:0] s, logic [15:0] l);
      stl_pkg::token_t t;
      t.kind   = k;
      t.start  = s;
      t.length = l;
      if (step_tokens.size() < 2) step_tokens.push_back(t);
    endfunction

    // Word bytes are stored first byte lowest, so the keywords read reversed
    function stl_pkg::kind_e word_kind();
      if (tok_len == 2 && word_bytes == {16'h0, "fi"}) return stl_pkg::KIND_IF;
      if (tok_len == 4 && word_bytes == "esle") return stl_pkg::KIND_ELSE;
      if (tok_len == 3 && word_bytes == {8'h0, "dna"}) return stl_pkg::KIND_AND;
      if (tok_len == 2 && word_bytes == {16'h0, "ro"}) return stl_pkg::KIND_OR;
      return stl_pkg::KIND_IDENT;
    endfunction

    // Close whatever token is open and go idle
    function void flush_token();
      case (state)
        LX_IDENT: add_token(word_kind(), tok_start, tok_len);
        LX_INT:   add_token(stl_pkg::KIND_INT, tok_start, tok_len);
        LX_OP: begin
          case (held_op)
            OP_ASSIGN: add_token(stl_pkg::KIND_ASSIGN, tok_start, 16'd1);
            OP_GT:     add_token(stl_pkg::KIND_GT, tok_start, 16'd1);
            OP_LT:     add_token(stl_pkg::KIND_LT, tok_start, 16'd1);
            default:   add_token(stl_pkg::KIND_ERROR, tok_start, 16'd1);
          endcase
        end
        default: ;
      endcase
      state = LX_IDLE;
    endfunction

    function void open_token(lex_state_e s, logic [7:0] b, logic [31:0] pos);
      state      = s;
      tok_start  = pos;
      tok_len    = 16'd1;
      word_bytes = {24'h0, b};
    endfunction

    // Lex one byte from the idle state
    function void lex_fresh(logic [7:0] b, logic [31:0] pos);
      if (is_letter(b)) begin
        open_token(LX_IDENT, b, pos);
      end else if (is_digit(b)) begin
        open_token(LX_INT, b, pos);
      end else if (b > 8'd32 && b < 8'd127) begin
        case (b)
          "=": begin open_token(LX_OP, b, pos); held_op = OP_ASSIGN; end
          ">": begin open_token(LX_OP, b, pos); held_op = OP_GT; end
          "<": begin open_token(LX_OP, b, pos); held_op = OP_LT; end
          "!": begin open_token(LX_OP, b, pos); held_op = OP_BANG; end
          "+": add_token(stl_pkg::KIND_PLUS, pos, 16'd1);
          "-": add_token(stl_pkg::KIND_MINUS, pos, 16'd1);
          "*": add_token(stl_pkg::KIND_STAR, pos, 16'd1);
          "(": add_token(stl_pkg::KIND_LPAREN, pos, 16'd1);
          ")": add_token(stl_pkg::KIND_RPAREN, pos, 16'd1);
          "{": add_token(stl_pkg::KIND_LBRACE, pos, 16'd1);
          "}": add_token(stl_pkg::KIND_RBRACE, pos, 16'd1);
          "/": add_token(stl_pkg::KIND_SLASH, pos, 16'd1);
          ";": add_token(stl_pkg::KIND_SEMI, pos, 16'd1);
          default: add_token(stl_pkg::KIND_ERROR, pos, 16'd1);
        endcase
      end
    endfunction

    // Accepted input transaction: predict the tokens it releases
    function void note_byte(logic [7:0] b, logic eoi);
      logic [31:0]     pos;
      expected_token_t e;
      step_tokens.delete();
      pos = next_offset;
      if (eoi) begin
        flush_token();
        add_token(stl_pkg::KIND_EOF, next_offset, 16'd0);
      end else begin
        if (next_offset != '1) next_offset++;
        if (state == LX_IDENT && (is_letter(b) || is_digit(b))) begin
          if (tok_len < 4) word_bytes |= {24'h0, b} << (8 * tok_len);
          if (tok_len != '1) tok_len++;
        end else if (state == LX_INT && is_digit(b)) begin
          if (tok_len != '1) tok_len++;
        end else if (state == LX_OP && b == "=") begin
          case (held_op)
            OP_ASSIGN: add_token(stl_pkg::KIND_EQ, tok_start, 16'd2);
            OP_GT:     add_token(stl_pkg::KIND_GE, tok_start, 16'd2);
            OP_LT:     add_token(stl_pkg::KIND_LE, tok_start, 16'd2);
            default:   add_token(stl_pkg::KIND_NE, tok_start, 16'd2);
          endcase
          state = LX_IDLE;
        end else begin
          flush_token();
          lex_fresh(b, pos);
        end
      end
      foreach (step_tokens[i]) begin
        e.tok  = step_tokens[i];
        e.last = (i == step_tokens.size() - 1);
        pending_tokens.push_back(e);
      end
    endfunction

    // Accepted result transaction: compare with the oldest prediction
    function void check_token(logic [4:0] kind, logic [31:0] start, logic [15:0] len,
                              logic last);
      expected_token_t e;
      if (pending_tokens.size() == 0) begin
        $error("unexpected token: kind %0d start %0d length %0d", kind, start, len);
        n_errors++;
        return;
      end
      e = pending_tokens.pop_front();
      if (kind !== e.tok.kind) begin
        $error("token_kind: expected %0d, got %0d", e.tok.kind, kind);
        n_errors++;
      end
      if (start !== e.tok.start) begin
        $error("token_start: expected %0d, got %0d", e.tok.start, start);
        n_errors++;
      end
      if (len !== e.tok.length) begin
        $error("token_length: expected %0d, got %0d", e.tok.length, len);
        n_errors++;
      end
      if (last !== e.last) begin
        $error("last_of_run: expected %0d, got %0d", e.last, last);
        n_errors++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_tokens.size();
    endfunction
  endclass
endpackage

module tb_top;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned RandItems  = 920;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        push           = 1'b0;
  logic        pop            = 1'b0;
  logic [7:0]  source_byte_i  = 8'h00;
  logic        end_of_input_i = 1'b0;
  logic        full;
  logic        empty;
  logic [4:0]  token_kind_o;
  logic [31:0] token_start_o;
  logic [15:0] token_length_o;
  logic        last_of_run_o;

  tb_lexer_pkg::token_scoreboard scoreboard;
  int unsigned     cycle_cnt    = 0;
  int unsigned     burst_left   = 0;
  int unsigned     items_sent   = 0;
  bit              hold_request = 1'b0;
  bit              hold_done    = 1'b0;

  // Near-keywords exercise the length and prefix checks
  string near_words[12] = '{"if", "else", "and", "or", "iff", "els", "elsee", "an",
                            "o", "_if", "IF", "ord"};
  string op_chars = "+-*(){}/;=<>!";
  string pair_lead = "=<>!";

  source_tokenizer_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .source_byte_i  (source_byte_i),
    .end_of_input_i (end_of_input_i),
    .empty          (empty),
    .pop            (pop),
    .token_kind_o   (token_kind_o),
    .token_start_o  (token_start_o),
    .token_length_o (token_length_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #10 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Observe both handshakes on pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) scoreboard.note_byte(source_byte_i, end_of_input_i);
    if (rst_ni && pop && !empty)
      scoreboard.check_token(token_kind_o, token_start_o, token_length_o, last_of_run_o);
  end

  // Offer one transaction, idling between bursts
  task automatic offer_byte(input logic [7:0] b, input logic eoi);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push           <= 1'b1;
    source_byte_i  <= b;
    end_of_input_i <= eoi;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  task automatic offer_text(input string s);
    for (int i = 0; i < s.len(); i++) offer_byte(s[i], 1'b0);
  endtask

  task automatic offer_eoi();
    offer_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Stop sending until every predicted token has been popped
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk_i); while (scoreboard.outstanding() != 0);
  endtask

  function automatic logic [7:0] ident_char(input bit lead);
    int unsigned r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  // One random lexeme, mostly well formed, some noise
  task automatic offer_lexeme();
    int unsigned n;
    case ($urandom_range(0, 15))
      0, 1: offer_text(near_words[$urandom_range(0, 11)]);
      2, 3, 4: begin
        offer_byte(ident_char(1'b1), 1'b0);
        n = $urandom_range(0, 8);
        repeat (n) offer_byte(ident_char(1'b0), 1'b0);
      end
      5, 6: begin
        n = $urandom_range(1, 6);
        repeat (n) offer_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
      end
      7, 8, 9: offer_byte(op_chars[$urandom_range(0, 12)], 1'b0);
      10, 11: begin
        offer_byte(pair_lead[$urandom_range(0, 3)], 1'b0);
        offer_byte("=", 1'b0);
      end
      12, 13: offer_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 32))
                                              : 8'($urandom_range(127, 255)), 1'b0);
      14: offer_byte(8'($urandom_range(0, 255)), 1'b0);
      default: begin
        if ($urandom_range(0, 3) == 0) offer_eoi();
        else offer_byte(" ", 1'b0);
      end
    endcase
  endtask

  // Receiver: segments of varying stall density, one long hold-off on request
  initial begin : receiver
    int unsigned seg;
    int unsigned mode;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      seg  = $urandom_range(10, 120);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        if (hold_request && !hold_done) begin
          hold_done = 1'b1;
          pop <= 1'b0;
          repeat (HoldCycles) @(posedge clk_i);
        end
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= 1'($urandom_range(0, 1));
          2:       pop <= ($urandom_range(0, 4) == 0);
          default: pop <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int unsigned phase_start;
    bit          paused;
    scoreboard = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Keywords, skipped bytes, lone bang, unknown byte, pairs, operators at end
    offer_text("if else");
    offer_byte(8'h7F, 1'b0);
    offer_text("and");
    offer_byte(8'hFF, 1'b0);
    offer_text("or!x#<=9");
    offer_eoi();
    offer_text("!");
    offer_eoi();
    offer_text(">");
    offer_eoi();
    offer_byte(8'h00, 1'b0);
    offer_text("a==");
    offer_eoi();
    drain_results();

    // Random lexemes; receiver holds off early on, sender pauses halfway
    hold_request = 1'b1;
    phase_start  = items_sent;
    paused       = 1'b0;
    while (items_sent - phase_start < RandItems) begin
      offer_lexeme();
      if (!paused && items_sent - phase_start >= RandItems / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
    offer_eoi();
    drain_results();
    repeat (10) @(posedge clk_i);

    if (scoreboard.n_errors == 0 && scoreboard.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: source_tokenizer_top.f
src/stl_pkg.sv
src/stl_front.sv
src/stl_queue.sv
src/stl_back.sv
src/source_tokenizer_top.sv
tb/tb_top.sv
